// File: rtl/core/line_edit_buffer_macros.svh
// assertion macros for the line edit buffer checker
`ifndef LINE_EDIT_BUFFER_MACROS_SVH
`define LINE_EDIT_BUFFER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define LEB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_edit_buffer check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define LEB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_edit_buffer check failed");

`endif

// File: rtl/core/leb_pkg.sv
// shared types and constants of the line edit buffer
`default_nettype none

package leb_pkg;

    localparam int LEB_CAPACITY = 64;

    typedef enum logic [1:0] {
        REQ_INSERT    = 2'd0,
        REQ_BACKSPACE = 2'd1,
        REQ_SET       = 2'd2,
        REQ_READ      = 2'd3
    } leb_req_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_REFUSED = 2'd1,
        STAT_CLAMPED = 2'd2
    } leb_status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_RD   = 2'd3
    } leb_cell_op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } leb_state_t;

    typedef struct packed {
        leb_req_t   req_type;
        logic [7:0] char_in;
        logic [6:0] position;
    } leb_req_beat_t;

    typedef struct packed {
        logic [6:0]  cursor_pos;
        logic [6:0]  line_length;
        logic [7:0]  char_out;
        leb_status_t status;
    } leb_rsp_beat_t;

endpackage

`default_nettype wire

// File: rtl/core/leb_cell.sv
// one character cell of the line chain, with its read relay stage
`default_nettype none

module leb_cell #(
    parameter int IDX = 0,
    parameter int EW  = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire leb_pkg::leb_cell_op_t op,
    input  wire logic [EW-1:0]        mark,
    input  wire logic [7:0]           ins_char,
    input  wire logic [7:0]           left_char,
    input  wire logic [7:0]           right_char,
    input  wire logic [7:0]           rd_in,
    output logic      [7:0]           char_q,
    output logic      [7:0]           rd_q
);

    logic [7:0] char_reg;
    logic [7:0] char_next;
    logic [7:0] rd_reg;
    logic [7:0] rd_next;

    always_comb
    begin
        char_next = char_reg;
        rd_next   = rd_reg;
        unique case (op)
            leb_pkg::CELL_INS:
            begin
                if (EW'(IDX) > mark)
                begin
                    char_next = left_char;
                end
                else if (EW'(IDX) == mark)
                begin
                    char_next = ins_char;
                end
            end
            leb_pkg::CELL_DEL:
            begin
                if (EW'(IDX) >= mark)
                begin
                    char_next = right_char;
                end
            end
            leb_pkg::CELL_RD:
            begin
                rd_next = (EW'(IDX) == mark) ? char_reg : rd_in;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_reg <= '0;
        end
        else
        begin
            char_reg <= char_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
    end

    assign char_q = char_reg;
    assign rd_q   = rd_reg;

endmodule

`default_nettype wire

// File: rtl/core/line_edit_buffer.sv
// top level of the line edit buffer: cursor and length control over a chain of cells
//
// usage
//   a request beat (req) is taken at a clock edge where start is high and busy is low.
//   every request gives one result beat on rsp, marked by done for exactly one cycle.
//   insert, backspace and set cursor finish in one cycle: done rises in the cycle
//   after the request, and a new request may be taken in that same cycle, so these
//   run at one beat per cycle.
//   read walks the selected character down the chain one cell per cycle towards
//   cell zero: busy stays high while the walk runs the full length of the chain,
//   and done rises as busy falls.
//   the receiver cannot stall; each result beat is shown once and is then gone.
//   reset clears every cell, the cursor and the length at once and drops any read
//   in flight; no clearing pass is needed.
`default_nettype none

module line_edit_buffer #(
    parameter int CAPACITY = leb_pkg::LEB_CAPACITY
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire leb_pkg::leb_req_beat_t req,
    output logic                        busy,
    output logic                        done,
    output leb_pkg::leb_rsp_beat_t      rsp
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int EW = (IW > 7) ? IW : 7;

    leb_pkg::leb_state_t    state_reg;
    leb_pkg::leb_state_t    state_next;
    logic [IW-1:0]          count_reg;
    logic [IW-1:0]          count_next;
    logic [IW-1:0]          cursor_reg;
    logic [IW-1:0]          cursor_next;
    logic [IW-1:0]          length_reg;
    logic [IW-1:0]          length_next;
    logic [EW-1:0]          pos_reg;
    logic [EW-1:0]          pos_next;
    logic                   done_reg;
    logic                   done_next;
    leb_pkg::leb_rsp_beat_t rsp_reg;
    leb_pkg::leb_rsp_beat_t rsp_next;

    leb_pkg::leb_cell_op_t  cell_op;
    logic [EW-1:0]          cell_mark;
    logic [7:0]             cell_char [CAPACITY];
    logic [7:0]             cell_rd   [CAPACITY];
    logic                   accept;

    assign accept = start && (state_reg == leb_pkg::ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            leb_pkg::ST_IDLE:
            begin
                if (accept && (req.req_type == leb_pkg::REQ_READ))
                begin
                    state_next = leb_pkg::ST_READ;
                    count_next = IW'(CAPACITY);
                end
            end
            leb_pkg::ST_READ:
            begin
                if (count_reg == '0)
                begin
                    state_next = leb_pkg::ST_IDLE;
                end
                else
                begin
                    count_next = count_reg - IW'(1);
                end
            end
            default:
            begin
                state_next = leb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and edit control
    always_comb
    begin
        cell_op     = leb_pkg::CELL_HOLD;
        cell_mark   = '0;
        cursor_next = cursor_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        unique case (state_reg)
            leb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.status   = leb_pkg::STAT_DONE;
                    rsp_next.char_out = '0;
                    done_next         = 1'b1;
                    case (req.req_type)
                        leb_pkg::REQ_INSERT:
                        begin
                            if ((length_reg == IW'(CAPACITY)) || (req.char_in == 8'd0))
                            begin
                                rsp_next.status = leb_pkg::STAT_REFUSED;
                            end
                            else
                            begin
                                cell_op     = leb_pkg::CELL_INS;
                                cell_mark   = EW'(cursor_reg);
                                cursor_next = cursor_reg + IW'(1);
                                length_next = length_reg + IW'(1);
                            end
                        end
                        leb_pkg::REQ_BACKSPACE:
                        begin
                            if (cursor_reg == '0)
                            begin
                                rsp_next.status = leb_pkg::STAT_REFUSED;
                            end
                            else
                            begin
                                cell_op     = leb_pkg::CELL_DEL;
                                cell_mark   = EW'(cursor_reg - IW'(1));
                                cursor_next = cursor_reg - IW'(1);
                                length_next = length_reg - IW'(1);
                            end
                        end
                        leb_pkg::REQ_SET:
                        begin
                            if (EW'(req.position) > EW'(length_reg))
                            begin
                                cursor_next     = length_reg;
                                rsp_next.status = leb_pkg::STAT_CLAMPED;
                            end
                            else
                            begin
                                cursor_next = IW'(req.position);
                            end
                        end
                        default:
                        begin
                            pos_next  = EW'(req.position);
                            done_next = 1'b0;
                        end
                    endcase
                    rsp_next.cursor_pos  = 7'(cursor_next);
                    rsp_next.line_length = 7'(length_next);
                end
            end
            leb_pkg::ST_READ:
            begin
                if (count_reg != '0)
                begin
                    cell_op   = leb_pkg::CELL_RD;
                    cell_mark = pos_reg;
                end
                else
                begin
                    done_next            = 1'b1;
                    rsp_next.cursor_pos  = 7'(cursor_reg);
                    rsp_next.line_length = 7'(length_reg);
                    rsp_next.char_out    = cell_rd[0];
                    rsp_next.status      = leb_pkg::STAT_DONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [7:0] left_c;
        logic [7:0] right_c;
        logic [7:0] rd_c;

        if (i == 0)
        begin : g_first
            assign left_c = 8'd0;
        end
        else
        begin : g_inner_l
            assign left_c = cell_char[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_c = 8'd0;
            assign rd_c    = 8'd0;
        end
        else
        begin : g_inner_r
            assign right_c = cell_char[i+1];
            assign rd_c    = cell_rd[i+1];
        end

        leb_cell #(
            .IDX (i),
            .EW  (EW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (cell_op),
            .mark       (cell_mark),
            .ins_char   (req.char_in),
            .left_char  (left_c),
            .right_char (right_c),
            .rd_in      (rd_c),
            .char_q     (cell_char[i]),
            .rd_q       (cell_rd[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= leb_pkg::ST_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
            length_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            length_reg <= length_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg == leb_pkg::ST_READ);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/core/leb_checker.sv
// port-level checks of the line edit buffer, bound to the top level
`default_nettype none

`include "line_edit_buffer_macros.svh"

module leb_checker #(
    parameter int CAPACITY = leb_pkg::LEB_CAPACITY
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire logic                   done,
    input wire leb_pkg::leb_rsp_beat_t rsp
);

    // a taken request either answers next cycle or starts a read walk
    `LEB_ASSERT_NEXT(a_req_answered, start && !busy, done || busy)

    // a result beat never overlaps a read walk
    `LEB_ASSERT_NOW(a_done_not_busy, done, !busy)

    // clamped cursor lands on the end of the line
    `LEB_ASSERT_NOW(a_clamp_at_end, done && (rsp.status == leb_pkg::STAT_CLAMPED),
                    rsp.cursor_pos == rsp.line_length)

    // cursor never passes the end of the line, nor the line its capacity
    `LEB_ASSERT_NOW(a_cursor_in_line, done && (CAPACITY < 128),
                    (rsp.cursor_pos <= rsp.line_length) && (rsp.line_length <= 7'(CAPACITY)))

    // a character comes back only on a completed beat
    `LEB_ASSERT_NOW(a_char_done, done && (rsp.char_out != 8'd0),
                    rsp.status == leb_pkg::STAT_DONE)

endmodule

bind line_edit_buffer leb_checker #(.CAPACITY(CAPACITY)) u_leb_checker (.*);

`default_nettype wire

// File: tb/line_edit_buffer_checker.sv
// checker for the line edit buffer: tracks the line and cursor, predicts each result beat and compares
`timescale 1ns / 1ps

module line_edit_buffer_checker #(
    parameter int CAPACITY = leb_pkg::LEB_CAPACITY
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  leb_pkg::leb_req_beat_t req,
    input  logic                   done,
    input  leb_pkg::leb_rsp_beat_t rsp,
    output int                     mismatch_count,
    output int                     pending_count,
    output int                     compared_count
);

    localparam int PRINT_CAP = 200;

    logic [7:0]             line_text [CAPACITY];
    int unsigned            line_cursor;
    int unsigned            line_len;
    leb_pkg::leb_rsp_beat_t expected_rsp [$];
    int                     fail_tally;
    int                     beats_seen;
    int                     pend_tally;

    assign mismatch_count = fail_tally;
    assign pending_count  = pend_tally;
    assign compared_count = beats_seen;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_tally < PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_tally++;
    endtask

    function automatic leb_pkg::leb_rsp_beat_t edit_line(input leb_pkg::leb_req_beat_t b);
        leb_pkg::leb_rsp_beat_t r;
        int unsigned            pos;
        r        = '0;
        r.status = leb_pkg::STAT_DONE;
        pos      = b.position;
        case (b.req_type)
            leb_pkg::REQ_INSERT:
            begin
                if (line_len >= CAPACITY || b.char_in == 8'd0 || line_cursor > line_len)
                    r.status = leb_pkg::STAT_REFUSED;
                else
                begin
                    for (int unsigned i = line_len; i > line_cursor; i--)
                        if (i < CAPACITY)
                            line_text[i] = line_text[i - 1];
                    line_text[line_cursor] = b.char_in;
                    line_cursor++;
                    line_len++;
                end
            end
            leb_pkg::REQ_BACKSPACE:
            begin
                if (line_cursor == 0 || line_cursor > line_len)
                    r.status = leb_pkg::STAT_REFUSED;
                else
                begin
                    for (int unsigned i = line_cursor - 1; i + 1 < line_len; i++)
                        line_text[i] = line_text[i + 1];
                    if (line_len > 0 && line_len - 1 < CAPACITY)
                        line_text[line_len - 1] = 8'd0;
                    line_cursor--;
                    line_len--;
                end
            end
            leb_pkg::REQ_SET:
            begin
                if (pos > line_len)
                begin
                    line_cursor = line_len;
                    r.status    = leb_pkg::STAT_CLAMPED;
                end
                else
                    line_cursor = pos;
            end
            default:
            begin
                if (pos < line_len && pos < CAPACITY)
                    r.char_out = line_text[pos];
            end
        endcase
        r.cursor_pos  = line_cursor[6:0];
        r.line_length = line_len[6:0];
        return r;
    endfunction

    initial
    begin
        fail_tally = 0;
        beats_seen = 0;
        pend_tally = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        leb_pkg::leb_rsp_beat_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                line_text[i] = 8'd0;
            line_cursor = 0;
            line_len    = 0;
            expected_rsp.delete();
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("result beat with none outstanding", int'(rsp.status), -1);
                else
                begin
                    want = expected_rsp.pop_front();
                    beats_seen++;
                    if (rsp.cursor_pos !== want.cursor_pos)
                        report_mismatch("cursor_pos", int'(rsp.cursor_pos),
                                        int'(want.cursor_pos));
                    if (rsp.line_length !== want.line_length)
                        report_mismatch("line_length", int'(rsp.line_length),
                                        int'(want.line_length));
                    if (rsp.char_out !== want.char_out)
                        report_mismatch("char_out", int'(rsp.char_out), int'(want.char_out));
                    if (rsp.status !== want.status)
                        report_mismatch("status", int'(rsp.status), int'(want.status));
                end
            end
            else if (done !== 1'b0)
                report_mismatch("done unknown", 0, 0);
            if (start && busy === 1'b0)
                expected_rsp.push_back(edit_line(req));
        end
        pend_tally = expected_rsp.size();
    end

endmodule

// File: tb/line_edit_buffer_tb.sv
// testbench top for the line edit buffer: clock, reset, request stimulus, watchdog and verdict
`timescale 1ns / 1ps

module line_edit_buffer_tb;

    localparam int CAPACITY     = leb_pkg::LEB_CAPACITY;
    localparam int RANDOM_BEATS = 930;
    localparam int STALL_LIMIT  = 16 * (CAPACITY + 2);
    localparam int DRAIN_CYCLES = CAPACITY + 8;

    logic                   clk   = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    leb_pkg::leb_req_beat_t req   = '0;
    logic                   busy;
    logic                   done;
    leb_pkg::leb_rsp_beat_t rsp;

    int mismatch_count;
    int pending_count;
    int compared_count;
    int stall_cycles = 0;
    int sent_by_type [4] = '{default: 0};
    int idle_pct = 0;

    always #1 clk = ~clk;

    line_edit_buffer #(.CAPACITY(CAPACITY)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    line_edit_buffer_checker #(.CAPACITY(CAPACITY)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req            (req),
        .done           (done),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .compared_count (compared_count)
    );

    // cycles with neither a request nor a result beat taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat taken for %0d cycles", stall_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic leb_pkg::leb_req_beat_t make_req(input leb_pkg::leb_req_t t,
                                                        input int ch, input int pos);
        leb_pkg::leb_req_beat_t b;
        b.req_type = t;
        b.char_in  = ch[7:0];
        b.position = pos[6:0];
        return b;
    endfunction

    // entered and left just after a falling edge
    task automatic send_req(input leb_pkg::leb_req_beat_t b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= b;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sent_by_type[int'(b.req_type)]++;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                seg_left;
        int                mode;
        int                roll;
        int                ch;
        int                pos;
        leb_pkg::leb_req_t kind;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idle_pct = 33;
        send_req(make_req(leb_pkg::REQ_READ, 8'h00, 0));
        send_req(make_req(leb_pkg::REQ_BACKSPACE, 8'hFF, 127));
        send_req(make_req(leb_pkg::REQ_INSERT, 8'h00, 0));
        send_req(make_req(leb_pkg::REQ_SET, 8'h00, 127));
        send_req(make_req(leb_pkg::REQ_INSERT, 8'hFF, 127));
        send_req(make_req(leb_pkg::REQ_INSERT, 8'h01, 0));
        send_req(make_req(leb_pkg::REQ_INSERT, 8'h80, 64));
        send_req(make_req(leb_pkg::REQ_SET, 8'hFF, 1));
        send_req(make_req(leb_pkg::REQ_INSERT, 8'h7F, 0));
        send_req(make_req(leb_pkg::REQ_READ, 8'hFF, 0));
        send_req(make_req(leb_pkg::REQ_READ, 8'h00, 1));
        send_req(make_req(leb_pkg::REQ_READ, 8'h00, 3));
        send_req(make_req(leb_pkg::REQ_READ, 8'h00, 4));
        send_req(make_req(leb_pkg::REQ_READ, 8'h00, 127));
        send_req(make_req(leb_pkg::REQ_SET, 8'h00, 0));
        send_req(make_req(leb_pkg::REQ_BACKSPACE, 8'h00, 0));
        send_req(make_req(leb_pkg::REQ_SET, 8'h00, 4));
        send_req(make_req(leb_pkg::REQ_BACKSPACE, 8'h00, 0));
        send_req(make_req(leb_pkg::REQ_READ, 8'h00, 3));
        send_req(make_req(leb_pkg::REQ_SET, 8'h00, 2));
        send_req(make_req(leb_pkg::REQ_BACKSPACE, 8'h00, 0));
        send_req(make_req(leb_pkg::REQ_SET, 8'h00, 64));
        send_req(make_req(leb_pkg::REQ_INSERT, 8'h55, 127));
        send_req(make_req(leb_pkg::REQ_READ, 8'h00, 2));

        // random segments: fill, drain or mixed traffic
        seg_left = 0;
        mode     = 0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n < RANDOM_BEATS / 3)
                idle_pct = 33;
            else if (n < 2 * RANDOM_BEATS / 3)
                idle_pct = 88;
            else
                idle_pct = 0;
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 100);
                mode     = $urandom_range(0, 3);
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            case (mode)
                0:       kind = roll < 85 ? leb_pkg::REQ_INSERT :
                                roll < 90 ? leb_pkg::REQ_SET : leb_pkg::REQ_READ;
                1:       kind = roll < 10 ? leb_pkg::REQ_INSERT :
                                roll < 80 ? leb_pkg::REQ_BACKSPACE :
                                roll < 90 ? leb_pkg::REQ_SET : leb_pkg::REQ_READ;
                default: kind = roll < 30 ? leb_pkg::REQ_INSERT :
                                roll < 50 ? leb_pkg::REQ_BACKSPACE :
                                roll < 75 ? leb_pkg::REQ_SET : leb_pkg::REQ_READ;
            endcase
            ch  = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 255);
            pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 65);
            send_req(make_req(kind, ch, pos));
        end
        start <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests: %0d insert, %0d backspace, %0d set cursor, %0d read",
                 sent_by_type[int'(leb_pkg::REQ_INSERT)]
                     + sent_by_type[int'(leb_pkg::REQ_BACKSPACE)]
                     + sent_by_type[int'(leb_pkg::REQ_SET)]
                     + sent_by_type[int'(leb_pkg::REQ_READ)],
                 sent_by_type[int'(leb_pkg::REQ_INSERT)],
                 sent_by_type[int'(leb_pkg::REQ_BACKSPACE)],
                 sent_by_type[int'(leb_pkg::REQ_SET)],
                 sent_by_type[int'(leb_pkg::REQ_READ)]);
        $display("%0d result beats compared, %0d mismatches", compared_count, mismatch_count);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
